/* rtl/asl_pkg.sv */
// asl_pkg: shared constants, codes and control structs for the semaphore
// wait queue table. No dependencies.
`default_nettype none
package asl_pkg;
    localparam int MaxProcs = 16;
    localparam int PidW     = $clog2(MaxProcs);
    localparam int DescW    = $clog2(MaxProcs);
    localparam int KeyW     = 31;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_OUT    = 2'd2,
        OP_HEAD   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_BAD_PROC = 2'd3
    } status_t;

    // controller -> datapath commands
    typedef struct packed {
        logic latch;      // capture input word
        logic scan_clr;   // reset scan counter
        logic scan_step;  // examine one descriptor / one link
        logic walk_init;  // begin link walk from queue head
        logic do_insert;  // commit insert
        logic do_unlink;  // commit unlink of target process
        logic emit;       // pulse result
        status_t st;      // status to report
    } asl_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        op_t  op;
        logic proc_blocked;   // target process is blocked
        logic scan_done;      // scan counter passed last descriptor
        logic key_found;      // matching descriptor located
        logic free_found;     // a free descriptor located
        logic walk_hit;       // predecessor of target located, or target is queue head
        logic walk_end;       // walk reached queue tail or scan counter passed last entry
    } asl_stat_t;
endpackage
`default_nettype wire

/* rtl/semaphore_wait_queue_table.sv */
// semaphore_wait_queue_table: top level, joins controller and datapath.
// Depends on asl_pkg, asl_ctrl, asl_datapath.
//
// Usage: present op, sem_key and proc_id with start high while busy is low;
// the word is taken at that edge. busy then stays high until the result.
// One result word per command appears on status, result_proc and
// sem_released for one cycle, marked by strobe; it cannot be held off.
// Sequence: an insert/out of a process in the wrong state is rejected in
// the decode state; insert, remove, head scan every descriptor (one
// descriptor per cycle) and then check; out of a named process walks the
// queue links, one link per cycle, and then unlinks.
// A new command may be given in the cycle strobe is high.
// Reset clears the controller, all descriptor in-use flags and all
// process blocked flags; keys and links need no clearing.
`default_nettype none
module semaphore_wait_queue_table (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               op,
    input  wire logic [asl_pkg::KeyW-1:0] sem_key,
    input  wire logic [asl_pkg::PidW-1:0] proc_id,
    output logic                          strobe,
    output logic [1:0]                    status,
    output logic [asl_pkg::PidW-1:0]      result_proc,
    output logic                          sem_released
);
    asl_pkg::asl_cmd_t  cmd;
    asl_pkg::asl_stat_t stat;

    asl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .stat(stat), .cmd(cmd)
    );

    asl_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .op(op), .sem_key(sem_key),
        .proc_id(proc_id), .cmd(cmd), .stat(stat), .strobe(strobe),
        .status(status), .result_proc(result_proc),
        .sem_released(sem_released)
    );

    // a result only follows an accepted word
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy)) else $error("strobe without command");
    // error results carry no process id
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status != 2'd0 |-> result_proc == '0 && !sem_released)
        else $error("error result carries data");
    // inserts never release
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_insert |-> !cmd.do_unlink) else $error("insert and unlink");
endmodule
`default_nettype wire

/* rtl/asl_datapath.sv */
// asl_datapath: descriptor table, process link table and scan/walk logic.
// Depends on asl_pkg.
`default_nettype none
module asl_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [1:0]                   op,
    input  wire logic [asl_pkg::KeyW-1:0]     sem_key,
    input  wire logic [asl_pkg::PidW-1:0]     proc_id,
    input  wire asl_pkg::asl_cmd_t            cmd,
    output asl_pkg::asl_stat_t                stat,
    output logic                              strobe,
    output logic [1:0]                        status,
    output logic [asl_pkg::PidW-1:0]          result_proc,
    output logic                              sem_released
);
    localparam int N = asl_pkg::MaxProcs;
    localparam int DW = asl_pkg::DescW;
    localparam int PW = asl_pkg::PidW;

    // tables
    logic [asl_pkg::KeyW-1:0] key_reg  [N];
    logic [PW-1:0]            head_reg [N];
    logic [PW-1:0]            tail_reg [N];
    logic [PW-1:0]            next_reg [N];
    logic [N-1:0]             used_reg;
    logic [N-1:0]             blk_reg;     // process blocked
    logic [DW-1:0]            bon_reg [N]; // descriptor blocked on

    // latched word and scan state
    logic [1:0]               op_reg;
    logic [asl_pkg::KeyW-1:0] skey_reg;
    logic [PW-1:0]            pid_reg;
    logic [DW:0]              cnt_reg;
    logic                     kfound_reg, ffound_reg;
    logic [DW-1:0]            kdesc_reg, fdesc_reg;
    logic [PW-1:0]            cur_reg;
    logic                     hit_reg;
    logic                     strobe_reg, rel_reg;
    logic [1:0]               status_reg;
    logic [PW-1:0]            rproc_reg;

    logic [DW-1:0] idx;
    logic [DW-1:0] tdesc;   // descriptor the target belongs to
    logic [PW-1:0] tproc;   // process to unlink
    assign idx = cnt_reg[DW-1:0];
    assign tdesc = (op_reg == asl_pkg::OP_OUT) ? bon_reg[pid_reg] : kdesc_reg;
    assign tproc = (op_reg == asl_pkg::OP_OUT) ? pid_reg : head_reg[kdesc_reg];

    always_comb
    begin
        stat.op           = asl_pkg::op_t'(op_reg);
        stat.proc_blocked = blk_reg[pid_reg];
        stat.scan_done    = cnt_reg[DW];
        stat.key_found    = kfound_reg;
        stat.free_found   = ffound_reg;
        stat.walk_hit     = hit_reg || (head_reg[tdesc] == tproc);
        stat.walk_end     = (cur_reg == tail_reg[tdesc]) || cnt_reg[DW];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            blk_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
            if (cmd.do_insert)
            begin
                if (!kfound_reg)
                    used_reg[fdesc_reg] <= 1'b1;
                blk_reg[pid_reg] <= 1'b1;
            end
            if (cmd.do_unlink)
            begin
                blk_reg[tproc] <= 1'b0;
                if (head_reg[tdesc] == tproc && tail_reg[tdesc] == tproc)
                    used_reg[tdesc] <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= op;
            skey_reg <= sem_key;
            pid_reg  <= proc_id;
        end
        if (cmd.scan_clr)
        begin
            cnt_reg    <= '0;
            kfound_reg <= 1'b0;
            ffound_reg <= 1'b0;
        end
        else if (cmd.walk_init)
        begin
            cnt_reg <= '0;
            cur_reg <= head_reg[tdesc];
            hit_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (op_reg == asl_pkg::OP_OUT)
            begin
                // link walk: look for predecessor of target
                if (next_reg[cur_reg] == pid_reg)
                    hit_reg <= 1'b1;
                else
                    cur_reg <= next_reg[cur_reg];
            end
            else
            begin
                if (used_reg[idx] && key_reg[idx] == skey_reg && !kfound_reg)
                begin
                    kfound_reg <= 1'b1;
                    kdesc_reg  <= idx;
                end
                if (!used_reg[idx] && !ffound_reg)
                begin
                    ffound_reg <= 1'b1;
                    fdesc_reg  <= idx;
                end
            end
        end
        if (cmd.do_insert)
        begin
            bon_reg[pid_reg] <= kfound_reg ? kdesc_reg : fdesc_reg;
            if (kfound_reg)
            begin
                next_reg[tail_reg[kdesc_reg]] <= pid_reg;
                tail_reg[kdesc_reg] <= pid_reg;
            end
            else
            begin
                key_reg[fdesc_reg]  <= skey_reg;
                head_reg[fdesc_reg] <= pid_reg;
                tail_reg[fdesc_reg] <= pid_reg;
            end
        end
        if (cmd.do_unlink)
        begin
            if (head_reg[tdesc] == tproc)
            begin
                if (tail_reg[tdesc] != tproc)
                    head_reg[tdesc] <= next_reg[tproc];
            end
            else if (hit_reg)
            begin
                next_reg[cur_reg] <= next_reg[tproc];
                if (tail_reg[tdesc] == tproc)
                    tail_reg[tdesc] <= cur_reg;
            end
        end
        if (cmd.emit)
        begin
            status_reg <= cmd.st;
            rel_reg    <= 1'b0;
            rproc_reg  <= '0;
            if (cmd.st == asl_pkg::ST_OK)
            begin
                rproc_reg <= (op_reg == asl_pkg::OP_INSERT) ? pid_reg : tproc;
                rel_reg   <= cmd.do_unlink && head_reg[tdesc] == tproc
                             && tail_reg[tdesc] == tproc;
            end
        end
    end

    assign strobe       = strobe_reg;
    assign status       = status_reg;
    assign result_proc  = rproc_reg;
    assign sem_released = rel_reg;
endmodule
`default_nettype wire

/* rtl/asl_ctrl.sv */
// asl_ctrl: operation sequencer for the semaphore wait queue table.
// Depends on asl_pkg.
`default_nettype none
module asl_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire asl_pkg::asl_stat_t stat,
    output asl_pkg::asl_cmd_t       cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_SCAN, S_CHECK, S_WALK, S_UNLINK
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        cmd.st     = asl_pkg::ST_OK;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.scan_clr = 1'b1;
                if (stat.op == asl_pkg::OP_OUT)
                begin
                    if (!stat.proc_blocked)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.st     = asl_pkg::ST_BAD_PROC;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_CHECK;
                end
                else if (stat.op == asl_pkg::OP_INSERT && stat.proc_blocked)
                begin
                    cmd.emit   = 1'b1;
                    cmd.st     = asl_pkg::ST_BAD_PROC;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                    state_next = S_CHECK;
                else
                    cmd.scan_step = 1'b1;
            end
            S_CHECK:
            begin
                case (stat.op)
                    asl_pkg::OP_INSERT:
                    begin
                        cmd.emit = 1'b1;
                        if (stat.key_found || stat.free_found)
                            cmd.do_insert = 1'b1;
                        else
                            cmd.st = asl_pkg::ST_NO_FREE;
                        state_next = S_IDLE;
                    end
                    asl_pkg::OP_HEAD:
                    begin
                        cmd.emit = 1'b1;
                        if (!stat.key_found)
                            cmd.st = asl_pkg::ST_ABSENT;
                        state_next = S_IDLE;
                    end
                    asl_pkg::OP_REMOVE:
                    begin
                        if (!stat.key_found)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.st     = asl_pkg::ST_ABSENT;
                            state_next = S_IDLE;
                        end
                        else
                            state_next = S_UNLINK;
                    end
                    default:
                    begin
                        cmd.walk_init = 1'b1;
                        state_next    = S_WALK;
                    end
                endcase
            end
            S_WALK:
            begin
                if (stat.walk_hit || stat.walk_end)
                    state_next = S_UNLINK;
                else
                    cmd.scan_step = 1'b1;
            end
            S_UNLINK:
            begin
                cmd.do_unlink = 1'b1;
                cmd.emit      = 1'b1;
                state_next    = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);
endmodule
`default_nettype wire
